/* rtl/sfdl_pkg.sv */
package sfdl_pkg;

  // Delay line geometry.
  localparam int LINE_DEPTH = 65536;
  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  // Field widths.
  localparam int IN_W   = 16;
  localparam int SMP_W  = 24;
  localparam int GAIN_W = 18;
  localparam int PROD_W = GAIN_W + SMP_W - 15;
  localparam int ACC_W  = 30;
  localparam int CFG_IW = 3;

  // Register reset values.
  localparam logic [15:0]              DELAY_RST = 16'd22050;
  localparam logic signed [GAIN_W-1:0] PRE_RST   = 18'sd29491;
  localparam logic signed [GAIN_W-1:0] FB_RST    = 18'sd8192;
  localparam logic signed [GAIN_W-1:0] A0_RST    = 18'sd5808;
  localparam logic signed [GAIN_W-1:0] A1_RST    = 18'sd11616;
  localparam logic signed [GAIN_W-1:0] A2_RST    = 18'sd5808;
  localparam logic signed [GAIN_W-1:0] A3_RST    = -18'sd16670;
  localparam logic signed [GAIN_W-1:0] A4_RST    = 18'sd7133;

  // The delay register is reduced modulo the line depth by repeated
  // compare and subtract of shifted copies of the depth.
  localparam int RED_STEPS = (LINE_DEPTH > 65535) ? 1 : $clog2(65536 / LINE_DEPTH) + 1;
  localparam int RK_W      = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
  localparam int CMP_W     = 22;
  localparam logic [AW-1:0] DMOD_RST = AW'(22050 % LINE_DEPTH);

  typedef enum logic [CFG_IW-1:0] {
    REG_DELAY = 3'd0,
    REG_PRE   = 3'd1,
    REG_FB    = 3'd2,
    REG_A0    = 3'd3,
    REG_A1    = 3'd4,
    REG_A2    = 3'd5,
    REG_A3    = 3'd6,
    REG_A4    = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_MAC  = 2'b10
  } state_e;

  typedef struct packed {
    logic acc_load;
    logic acc_add;
  } mac_ctrl_t;

  function automatic logic signed [SMP_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(signed'(24'sh7FFFFF));
    lo = ACC_W'(signed'(24'sh800000));
    if (v > hi) begin
      return 24'sh7FFFFF;
    end else if (v < lo) begin
      return 24'sh800000;
    end else begin
      return v[SMP_W-1:0];
    end
  endfunction

endpackage

/* rtl/sfdl_ram.sv */
module sfdl_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 65536
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/sfdl_mac.sv */
module sfdl_mac
  import sfdl_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mac_ctrl_t                ctrl_i,
  input  logic signed [GAIN_W-1:0] gain_i,
  input  logic signed [SMP_W-1:0]  value_i,
  output logic signed [ACC_W-1:0]  acc_o
);

  logic signed [GAIN_W+SMP_W-1:0] prod;
  logic signed [PROD_W-1:0]       prod_q;
  logic signed [ACC_W-1:0]        prod_ext;
  logic signed [ACC_W-1:0]        acc_d, acc_q;

  // Dropping the low 15 bits of the full product floors it to Q7.19.
  assign prod     = gain_i * value_i;
  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.acc_load) begin
      acc_d = prod_ext;
    end else if (ctrl_i.acc_add) begin
      acc_d = acc_q + prod_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      acc_q  <= '0;
    end else begin
      prod_q <= prod[GAIN_W+SMP_W-1:15];
      acc_q  <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

/* rtl/stereo_feedback_delay_lowpass.sv */
// Stereo feedback delay with a second-order low-pass filter in the loop.
// Input items arrive on the s_axis channel (left and right Q0.15 samples);
// one result item per input leaves on the m_axis channel (left and right
// Q4.19 dry plus delayed sample, saturated to 24 bits).
// Each channel runs through one shared 18x24 multiplier and accumulator:
// seven products per channel, in sequencer steps K_PRE to K_FIN. A new
// item is accepted only once both channels of the previous one are done.
// Both delay lines share one memory that is read once when the item is
// accepted and written once at the end.
// Writing the delay register starts a reduction of the delay modulo the
// line depth in RED_STEPS compare-and-subtract steps; s_axis_tready
// stays low meanwhile.
// Reset clears the pointer and filter history and loads the register reset values at once.
// Line entries never written since reset read as zero through a fill
// mark kept with the write pointer, so no clearing pass is needed.
// If the receiver stalls, the result waits in the output register; the next
// item is accepted, but its final step waits until the result is taken.
module stereo_feedback_delay_lowpass
  import sfdl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration write port.
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [GAIN_W-1:0] cfg_wdata_i,
  // Input stream.
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,   // left_in[15:0], right_in[31:16]
  // Output stream.
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [47:0]       m_axis_tdata    // left_out[23:0], right_out[47:24]
);

  // Sequencer step codes within one channel.
  localparam logic [3:0] K_PRE  = 4'd0;
  localparam logic [3:0] K_FB   = 4'd1;
  localparam logic [3:0] K_A1   = 4'd2;
  localparam logic [3:0] K_A2   = 4'd3;
  localparam logic [3:0] K_A3   = 4'd4;
  localparam logic [3:0] K_A4   = 4'd5;
  localparam logic [3:0] K_A0   = 4'd6;
  localparam logic [3:0] K_LAST = 4'd7;
  localparam logic [3:0] K_FIN  = 4'd8;

  // Configuration registers.
  logic signed [GAIN_W-1:0] pre_q, fb_q;
  logic signed [GAIN_W-1:0] a0_q, a1_q, a2_q, a3_q, a4_q;
  logic [15:0]              rem_q;
  logic [AW-1:0]            dmod_q;
  logic                     red_busy_q;
  logic [RK_W-1:0]          red_k_q;
  logic [CMP_W-1:0]         red_cmp;
  logic [15:0]              rem_next;

  // Sequencer state.
  state_e                   state_q;
  logic [3:0]               step_q;
  logic                     ch_q;
  logic [AW-1:0]            wp_q;
  logic                     full_q;
  logic                     rdv_q;
  logic                     zdel_q;
  logic signed [IN_W-1:0]   xl_q, xr_q;
  logic signed [SMP_W-1:0]  w_q;
  logic signed [SMP_W-1:0]  yl_q;
  logic signed [SMP_W-1:0]  lo_q;
  logic signed [SMP_W-1:0]  hist_q [2][4];
  logic                     ovalid_q;
  logic [47:0]              odata_q;

  // Address and datapath signals.
  logic                     accept;
  logic                     slot_free;
  logic                     finish;
  logic [AW-1:0]            wp_next;
  logic [AW:0]              rd_diff;
  logic [AW-1:0]            rd_addr;
  logic                     rd_valid;
  logic [47:0]              ram_rdata;
  logic signed [SMP_W-1:0]  dly;
  logic signed [IN_W-1:0]   x_cur;
  logic signed [SMP_W-1:0]  xq;
  mac_ctrl_t                mac_ctrl;
  logic signed [GAIN_W-1:0] mac_gain;
  logic signed [SMP_W-1:0]  mac_value;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SMP_W-1:0]  y;
  logic signed [SMP_W-1:0]  wet;
  logic signed [SMP_W-1:0]  out_cur;

  assign s_axis_tready = (state_q == ST_IDLE) && !red_busy_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !ovalid_q || m_axis_tready;
  assign finish        = (state_q == ST_MAC) && (step_q == K_FIN) && ch_q && slot_free;

  // Pointer advance and read address, both modulo the depth.
  assign wp_next  = (wp_q == AW'(LINE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
  assign rd_diff  = {1'b0, wp_next} - {1'b0, dmod_q};
  assign rd_addr  = rd_diff[AW] ? rd_diff[AW-1:0] + AW'(LINE_DEPTH) : rd_diff[AW-1:0];
  // Before the first wrap only the entries from 1 up to the pointer hold data.
  assign rd_valid = full_q || ((rd_addr != '0) && (rd_addr <= wp_q));

  sfdl_ram #(
    .WIDTH (48),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (finish),
    .waddr_i (wp_q),
    .wdata_i ({y, yl_q}),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  assign dly   = !rdv_q ? '0 : (ch_q ? ram_rdata[47:24] : ram_rdata[23:0]);
  assign x_cur = ch_q ? xr_q : xl_q;
  assign xq    = {{(SMP_W-IN_W-4){x_cur[IN_W-1]}}, x_cur, 4'b0000};

  // Operand selection for the shared multiplier.
  always_comb begin
    mac_gain  = '0;
    mac_value = '0;
    mac_ctrl  = '0;
    if (state_q == ST_MAC) begin
      case (step_q)
        K_PRE: begin
          mac_gain  = pre_q;
          mac_value = xq;
        end
        K_FB: begin
          mac_gain          = fb_q;
          mac_value         = dly;
          mac_ctrl.acc_load = 1'b1;
        end
        K_A1: begin
          mac_gain         = a1_q;
          mac_value        = hist_q[ch_q][0];
          mac_ctrl.acc_add = 1'b1;
        end
        K_A2: begin
          mac_gain          = a2_q;
          mac_value         = hist_q[ch_q][1];
          mac_ctrl.acc_load = 1'b1;
        end
        K_A3: begin
          mac_gain         = a3_q;
          mac_value        = hist_q[ch_q][2];
          mac_ctrl.acc_add = 1'b1;
        end
        K_A4: begin
          mac_gain         = a4_q;
          mac_value        = hist_q[ch_q][3];
          mac_ctrl.acc_add = 1'b1;
        end
        K_A0: begin
          mac_gain         = a0_q;
          mac_value        = w_q;
          mac_ctrl.acc_add = 1'b1;
        end
        K_LAST: begin
          mac_ctrl.acc_add = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  sfdl_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .gain_i  (mac_gain),
    .value_i (mac_value),
    .acc_o   (acc)
  );

  assign y = sat24(acc);
  // With zero delay the output sees the entry just written.
  assign wet     = zdel_q ? y : dly;
  assign out_cur = sat24(ACC_W'(xq) + ACC_W'(wet));

  // Delay reduction modulo the depth.
  assign red_cmp  = CMP_W'(LINE_DEPTH) << red_k_q;
  assign rem_next = ({{(CMP_W-16){1'b0}}, rem_q} >= red_cmp) ? rem_q - red_cmp[15:0] : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q      <= PRE_RST;
      fb_q       <= FB_RST;
      a0_q       <= A0_RST;
      a1_q       <= A1_RST;
      a2_q       <= A2_RST;
      a3_q       <= A3_RST;
      a4_q       <= A4_RST;
      rem_q      <= DELAY_RST;
      dmod_q     <= DMOD_RST;
      red_busy_q <= 1'b0;
      red_k_q    <= '0;
    end else begin
      if (red_busy_q) begin
        rem_q   <= rem_next;
        red_k_q <= red_k_q - 1'b1;
        if (red_k_q == '0) begin
          red_busy_q <= 1'b0;
          dmod_q     <= AW'(rem_next);
        end
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          REG_DELAY: begin
            rem_q      <= cfg_wdata_i[15:0];
            red_busy_q <= 1'b1;
            red_k_q    <= RK_W'(RED_STEPS - 1);
          end
          REG_PRE: pre_q <= cfg_wdata_i;
          REG_FB:  fb_q  <= cfg_wdata_i;
          REG_A0:  a0_q  <= cfg_wdata_i;
          REG_A1:  a1_q  <= cfg_wdata_i;
          REG_A2:  a2_q  <= cfg_wdata_i;
          REG_A3:  a3_q  <= cfg_wdata_i;
          REG_A4:  a4_q  <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= K_PRE;
      ch_q     <= 1'b0;
      wp_q     <= '0;
      full_q   <= 1'b0;
      rdv_q    <= 1'b0;
      zdel_q   <= 1'b0;
      ovalid_q <= 1'b0;
      hist_q   <= '{default: '0};
    end else begin
      if (ovalid_q && m_axis_tready && !finish) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_MAC;
            step_q  <= K_PRE;
            ch_q    <= 1'b0;
            wp_q    <= wp_next;
            rdv_q   <= rd_valid;
            zdel_q  <= (dmod_q == '0);
          end
        end
        ST_MAC: begin
          if (step_q != K_FIN) begin
            step_q <= step_q + 1'b1;
          end else if (!ch_q || slot_free) begin
            hist_q[ch_q][0] <= w_q;
            hist_q[ch_q][1] <= hist_q[ch_q][0];
            hist_q[ch_q][2] <= y;
            hist_q[ch_q][3] <= hist_q[ch_q][2];
            step_q          <= K_PRE;
            if (!ch_q) begin
              ch_q <= 1'b1;
            end else begin
              state_q  <= ST_IDLE;
              ovalid_q <= 1'b1;
              if (wp_q == '0) begin
                full_q <= 1'b1;
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      xl_q <= s_axis_tdata[15:0];
      xr_q <= s_axis_tdata[31:16];
    end
    if ((state_q == ST_MAC) && (step_q == K_A2)) begin
      w_q <= y;
    end
    if ((state_q == ST_MAC) && (step_q == K_FIN) && !ch_q) begin
      yl_q <= y;
      lo_q <= out_cur;
    end
    if (finish) begin
      odata_q <= {out_cur, lo_q};
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

endmodule

/* bench/tb_stereo_feedback_delay_lowpass.sv */
module tb_stereo_feedback_delay_lowpass;
  timeunit 1ns;
  timeprecision 1ps;

  import sfdl_pkg::*;

  localparam int PHASE_ITEMS   = 75;
  localparam int RANDOM_PHASES = 8;
  localparam int HOLD_AT       = 200;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 2000;
  localparam int TAIL_CYCLES   = 40;

  typedef bit signed [SMP_W-1:0] q19_t;
  typedef int setting_t [8];

  typedef struct packed {
    logic signed [IN_W-1:0] right;
    logic signed [IN_W-1:0] left;
  } frame_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] right;
    logic signed [SMP_W-1:0] left;
  } echo_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [CFG_IW-1:0] cfg_idx_i     = REG_DELAY;
  logic [GAIN_W-1:0] cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata  = '0;  // left_in[15:0], right_in[31:16]
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [47:0]       m_axis_tdata;        // left_out[23:0], right_out[47:24]

  stereo_feedback_delay_lowpass dut (.*);

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Shadow of the block: registers, both delay lines and filter history.
  int     regs_m [8];
  q19_t   dline [2][LINE_DEPTH];
  q19_t   hist [2][4];
  logic [AW-1:0] wr_ptr = '0;

  frame_t frames_q [$];
  echo_t  echo_q [$];

  int tx_idle_pct = 20;
  int rx_idle_pct = 20;
  int frames_in   = 0;
  int results_out = 0;
  int fails       = 0;
  int sat_hits    = 0;
  int settings    = 1;
  int hold_left   = 0;
  bit hold_done   = 1'b0;
  int quiet       = 0;

  function automatic q19_t clamp24(longint v);
    if (v > 64'sd8388607) begin
      return q19_t'(24'sh7FFFFF);
    end else if (v < -64'sd8388608) begin
      return q19_t'(24'sh800000);
    end
    return q19_t'(v);
  endfunction

  // Q2.15 gain times Q4.19 value, floored to Q7.19.
  function automatic longint scale(int g, q19_t v);
    return (longint'(g) * longint'(v)) >>> 15;
  endfunction

  function automatic echo_t predict_echo(frame_t f);
    q19_t          x [2];
    q19_t          o [2];
    q19_t          w;
    q19_t          y;
    logic [AW-1:0] rd;
    echo_t         r;
    x[0] = q19_t'(f.left) <<< 4;
    x[1] = q19_t'(f.right) <<< 4;
    wr_ptr = wr_ptr + 1'b1;
    rd = wr_ptr - AW'(regs_m[REG_DELAY] % LINE_DEPTH);
    for (int ch = 0; ch < 2; ch++) begin
      w = clamp24(scale(regs_m[REG_PRE], x[ch]) + scale(regs_m[REG_FB], dline[ch][rd]));
      y = clamp24(scale(regs_m[REG_A0], w) + scale(regs_m[REG_A1], hist[ch][0]) +
                  scale(regs_m[REG_A2], hist[ch][1]) + scale(regs_m[REG_A3], hist[ch][2]) +
                  scale(regs_m[REG_A4], hist[ch][3]));
      hist[ch][1] = hist[ch][0];
      hist[ch][0] = w;
      hist[ch][3] = hist[ch][2];
      hist[ch][2] = y;
      dline[ch][wr_ptr] = y;
      // With a zero delay the tap is the entry just written.
      o[ch] = clamp24(longint'(x[ch]) + longint'(dline[ch][rd]));
      if (o[ch] == q19_t'(24'sh7FFFFF) || o[ch] == q19_t'(24'sh800000)) begin
        sat_hits++;
      end
    end
    r.left  = o[0];
    r.right = o[1];
    return r;
  endfunction

  // Sender: a new item is taken from the queue once the last one is gone.
  always @(posedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (frames_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        s_axis_tdata  <= frames_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver, with one long hold-off so that the block backs up.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && frames_in >= HOLD_AT) begin
        hold_left     <= HOLD_CYCLES;
        hold_done     <= 1'b1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    echo_t want;
    echo_t seen;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        echo_q.push_back(predict_echo(frame_t'(s_axis_tdata)));
        frames_in <= frames_in + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_out <= results_out + 1;
        seen = echo_t'(m_axis_tdata);
        if (echo_q.size() == 0) begin
          $error("result item with nothing pending: tdata %h", m_axis_tdata);
          fails++;
        end else begin
          want = echo_q.pop_front();
          if (seen.left !== want.left) begin
            $error("left_out: expected %0d, got %0d", want.left, seen.left);
            fails++;
          end
          if (seen.right !== want.right) begin
            $error("right_out: expected %0d, got %0d", want.right, seen.right);
            fails++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
        quiet <= 0;
      end else if (quiet == QUIET_LIMIT) begin
        $display("tb_stereo_feedback_delay_lowpass NOT OK");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // Waits until no item is queued, offered or awaiting its result.
  task automatic drain();
    while (frames_q.size() != 0 || s_axis_tvalid || echo_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic apply_setting(input setting_t s);
    drain();
    for (int i = 0; i < 8; i++) begin
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= cfg_idx_e'(i);
      cfg_wdata_i <= s[i][GAIN_W-1:0];
      if (cfg_idx_e'(i) == REG_DELAY) begin
        regs_m[i] = s[i] & 16'hFFFF;
      end else begin
        regs_m[i] = int'($signed(s[i][GAIN_W-1:0]));
      end
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings++;
    @(negedge clk_i);
  endtask

  function automatic setting_t random_setting();
    setting_t s;
    int       pick;
    pick = $urandom_range(9);
    if (pick < 6) begin
      s[REG_DELAY] = $urandom_range(48, 1);
    end else if (pick == 6) begin
      s[REG_DELAY] = 0;
    end else if (pick == 7) begin
      s[REG_DELAY] = 65535;
    end else begin
      s[REG_DELAY] = $urandom_range(65535);
    end
    // Each gain spans the whole register or stays within +/-1.0, with equal odds.
    for (int i = 1; i < 8; i++) begin
      if ($urandom_range(1) == 1) begin
        s[i] = int'($urandom_range(262143)) - 131072;
      end else begin
        s[i] = int'($urandom_range(65535)) - 32768;
      end
    end
    return s;
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    int     mode;
    mode = $urandom_range(9);
    if (mode < 6) begin
      f = frame_t'($urandom());
    end else if (mode < 9) begin
      f.left  = IN_W'(int'($urandom_range(4095)) - 2048);
      f.right = IN_W'(int'($urandom_range(4095)) - 2048);
    end else begin
      f.left  = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      f.right = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    end
    return f;
  endfunction

  task automatic push_directed();
    int lefts [6]  = '{0, 32767, -32768, 32767, -1, 21845};
    int rights [6] = '{0, 32767, -32768, -32768, 1, -21846};
    frame_t f;
    for (int i = 0; i < 6; i++) begin
      f.left  = IN_W'(lefts[i]);
      f.right = IN_W'(rights[i]);
      frames_q.push_back(f);
    end
  endtask

  initial begin
    setting_t s;
    regs_m[REG_DELAY] = DELAY_RST;
    regs_m[REG_PRE]   = PRE_RST;
    regs_m[REG_FB]    = FB_RST;
    regs_m[REG_A0]    = A0_RST;
    regs_m[REG_A1]    = A1_RST;
    regs_m[REG_A2]    = A2_RST;
    regs_m[REG_A3]    = A3_RST;
    regs_m[REG_A4]    = A4_RST;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings first, then zero delay with the largest gains,
    // the longest delay with the most negative gains, and a one-sample
    // loop with full positive feedback.
    push_directed();
    apply_setting('{0, 131071, -131072, 131071, 131071, 131071, -131072, 131071});
    push_directed();
    apply_setting('{65535, -131072, -131072, -131072, -131072, -131072, -131072, -131072});
    push_directed();
    apply_setting('{1, 131071, 131071, 32768, 0, 0, 0, 0});
    push_directed();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      s = random_setting();
      apply_setting(s);
      // One phase runs with no random idle cycles on either side.
      tx_idle_pct <= (p == 2) ? 0 : 20;
      rx_idle_pct <= (p == 2) ? 0 : 20;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        frames_q.push_back(random_frame());
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d items over %0d register settings; %0d results checked, %0d outputs saturated.",
             frames_in, settings, results_out, sat_hits);
    if (fails == 0 && echo_q.size() == 0) begin
      $display("tb_stereo_feedback_delay_lowpass OK");
    end else begin
      $display("tb_stereo_feedback_delay_lowpass NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/sfdl_pkg.sv
rtl/sfdl_ram.sv
rtl/sfdl_mac.sv
rtl/stereo_feedback_delay_lowpass.sv
bench/tb_stereo_feedback_delay_lowpass.sv
